// ===== rtl/cpfr_pkg.sv =====
// Shared types, codes and defaults for the checksummed pair frame receiver.
`timescale 1ns / 1ps

package cpfr_pkg;

  // Default number of table entries a frame may update
  localparam int PAIR_COUNT_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_END_MARKER    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_MARKER_RST  = 8'd2;
  localparam logic [7:0] END_MARKER_RST    = 8'd3;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_EQ,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       flag;
  } alu_rsp_t;

endpackage

// ===== rtl/cpfr_alu.sv =====
// Shared 8-bit add and compare unit used by the frame sequencer.
`timescale 1ns / 1ps

module cpfr_alu (
  input  cpfr_pkg::alu_req_t req,
  output cpfr_pkg::alu_rsp_t rsp
);
  import cpfr_pkg::*;

  logic [7:0] sum;

  assign sum = req.a + req.b;

  // Select the flag for the requested operation; an add flags a zero sum
  always_comb begin
    rsp.sum = sum;
    case (req.op)
      ALU_ADD: rsp.flag = (sum == 8'd0);
      ALU_EQ:  rsp.flag = (req.a == req.b);
      ALU_LT:  rsp.flag = (req.a < req.b);
      default: rsp.flag = 1'b0;
    endcase
  end

endmodule

// ===== rtl/checksummed_pair_frame_receiver_unit.sv =====
// Top level: frame parser with payload store and a sequencer around one shared ALU.
// Beats are taken one at a time: item_stall stays high until the sequencer is idle again.
// Each step runs through the shared ALU. A good end byte then emits each stored pair whose
// index is in range, read from the registered store, and closes with an ok status; result
// stalls hold the sequencer. A result may wait in the output register while the next beat
// is taken. Reset (rst, synchronous, active high) restores markers, timeout and counters;
// the payload store is not cleared.
`timescale 1ns / 1ps

module checksummed_pair_frame_receiver_unit #(
  parameter int PAIR_COUNT = cpfr_pkg::PAIR_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input beats
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  // result beats
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_status,
  output logic [2:0] status,
  output logic [3:0] entry_index,
  output logic [7:0] entry_value,
  output logic       last
);
  import cpfr_pkg::*;

  localparam int STORE_DEPTH = 2 * PAIR_COUNT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam logic [7:0] DEPTH_B = 8'(STORE_DEPTH);
  localparam logic [7:0] PAIRS_B = 8'(PAIR_COUNT);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK,
    PH_END
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_PAY_CNT,
    S_PAY_CMP,
    S_TICK_INC,
    S_TICK_CMP,
    S_E_CHK,
    S_E_IDX,
    S_E_VAL,
    S_STATUS
  } state_t;

  state_t     state;
  phase_t     phase;
  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic [7:0] timeout_ticks;
  logic [7:0] byte_q;
  logic [LEN_W-1:0] frame_length;
  logic [LEN_W-1:0] bytes_taken;
  logic [LEN_W-1:0] ptr;
  logic [7:0] running_sum;
  logic [7:0] elapsed_ticks;
  logic [2:0] status_q;
  logic [3:0] idx_q;
  logic       keep;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  alu_req_t req;
  alu_rsp_t rsp;
  logic     can_load;
  logic     load_beat;
  logic     in_frame;

  cpfr_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign item_stall = (state != S_IDLE);
  assign can_load   = !result_valid || !result_stall;
  assign load_beat  = can_load && ((state == S_E_VAL && keep) || (state == S_STATUS));
  assign in_frame   = (phase == PH_PAYLOAD) || (phase == PH_CHECK) || (phase == PH_END);

  // Read the index byte at the pair start, then the value byte right after it
  assign rd_addr = (state == S_E_CHK) ? ptr[ADDR_W-1:0] : (ptr[ADDR_W-1:0] | ADDR_W'(1));

  // Payload store: write during payload bytes, registered read for emission
  always_ff @(posedge clk) begin
    if (state == S_BYTE && phase == PH_PAYLOAD) begin
      store[bytes_taken[ADDR_W-1:0]] <= byte_q;
    end
    rd_data <= store[rd_addr];
  end

  // Drive the shared unit from the current step
  always_comb begin
    req.op = ALU_EQ;
    req.a  = byte_q;
    req.b  = start_marker;
    case (state)
      S_BYTE: begin
        case (phase)
          PH_LEN: begin
            req.op = ALU_LT;
            req.a  = DEPTH_B;
            req.b  = byte_q;
          end
          PH_PAYLOAD, PH_CHECK: begin
            req.op = ALU_ADD;
            req.a  = byte_q;
            req.b  = running_sum;
          end
          PH_END: begin
            req.b = end_marker;
          end
          default: begin
            req.b = start_marker;
          end
        endcase
      end
      S_PAY_CNT: begin
        req.op = ALU_ADD;
        req.a  = 8'(bytes_taken);
        req.b  = 8'd1;
      end
      S_PAY_CMP: begin
        req.op = ALU_LT;
        req.a  = 8'(bytes_taken);
        req.b  = 8'(frame_length);
      end
      S_TICK_INC: begin
        req.op = ALU_ADD;
        req.a  = elapsed_ticks;
        req.b  = {7'd0, (elapsed_ticks != 8'hFF)};
      end
      S_TICK_CMP: begin
        req.op = ALU_LT;
        req.a  = elapsed_ticks;
        req.b  = timeout_ticks;
      end
      S_E_CHK: begin
        req.op = ALU_LT;
        req.a  = 8'(ptr);
        req.b  = 8'(frame_length);
      end
      S_E_IDX: begin
        req.op = ALU_LT;
        req.a  = rd_data;
        req.b  = PAIRS_B;
      end
      S_E_VAL: begin
        req.op = ALU_ADD;
        req.a  = 8'(ptr);
        req.b  = 8'd2;
      end
      default: begin
        req.op = ALU_EQ;
      end
    endcase
  end

  // Sequencer, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_HUNT;
      start_marker  <= START_MARKER_RST;
      end_marker    <= END_MARKER_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
      frame_length  <= '0;
      bytes_taken   <= '0;
      running_sum   <= 8'd0;
      elapsed_ticks <= 8'd0;
      result_valid  <= 1'b0;
    end else begin
      // Take registers from the write port
      if (cfg_write) begin
        case (cfg_index)
          CFG_START_MARKER:  start_marker  <= cfg_data;
          CFG_END_MARKER:    end_marker    <= cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result beat once it is taken, unless a new one replaces it
      if (result_valid && !result_stall && !load_beat) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            byte_q <= rx_byte;
            if (!mode) begin
              state <= S_BYTE;
            end else if (in_frame) begin
              state <= S_TICK_INC;
            end
          end
        end
        S_BYTE: begin
          case (phase)
            PH_HUNT: begin
              if (rsp.flag) begin
                phase <= PH_LEN;
              end
              state <= S_IDLE;
            end
            PH_LEN: begin
              if (rsp.flag || byte_q[0]) begin
                status_q <= ST_BAD_LEN;
                state    <= S_STATUS;
              end else begin
                frame_length  <= byte_q[LEN_W-1:0];
                bytes_taken   <= '0;
                running_sum   <= 8'd0;
                elapsed_ticks <= 8'd0;
                phase         <= (byte_q == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                state         <= S_IDLE;
              end
            end
            PH_PAYLOAD: begin
              running_sum <= rsp.sum;
              state       <= S_PAY_CNT;
            end
            PH_CHECK: begin
              if (rsp.flag) begin
                phase <= PH_END;
                state <= S_IDLE;
              end else begin
                status_q <= ST_CHECKSUM;
                state    <= S_STATUS;
              end
            end
            PH_END: begin
              if (rsp.flag) begin
                ptr   <= '0;
                state <= S_E_CHK;
              end else begin
                status_q <= ST_END;
                state    <= S_STATUS;
              end
            end
            default: begin
              phase <= PH_HUNT;
              state <= S_IDLE;
            end
          endcase
        end
        S_PAY_CNT: begin
          bytes_taken <= rsp.sum[LEN_W-1:0];
          state       <= S_PAY_CMP;
        end
        S_PAY_CMP: begin
          if (!rsp.flag) begin
            phase <= PH_CHECK;
          end
          state <= S_IDLE;
        end
        S_TICK_INC: begin
          elapsed_ticks <= rsp.sum;
          state         <= S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (!rsp.flag) begin
            status_q <= ST_TIMEOUT;
            state    <= S_STATUS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_E_CHK: begin
          if (rsp.flag) begin
            state <= S_E_IDX;
          end else begin
            status_q <= ST_OK;
            state    <= S_STATUS;
          end
        end
        S_E_IDX: begin
          keep  <= rsp.flag;
          idx_q <= rd_data[3:0];
          state <= S_E_VAL;
        end
        S_E_VAL: begin
          // Skip pairs whose index is out of range, else hold until the output frees
          if (!keep) begin
            ptr   <= rsp.sum[LEN_W-1:0];
            state <= S_E_CHK;
          end else if (can_load) begin
            result_valid <= 1'b1;
            is_status    <= 1'b0;
            status       <= ST_OK;
            entry_index  <= idx_q;
            entry_value  <= rd_data;
            last         <= 1'b0;
            ptr          <= rsp.sum[LEN_W-1:0];
            state        <= S_E_CHK;
          end
        end
        S_STATUS: begin
          if (can_load) begin
            result_valid <= 1'b1;
            is_status    <= 1'b1;
            status       <= status_q;
            entry_index  <= 4'd0;
            entry_value  <= 8'd0;
            last         <= 1'b1;
            phase        <= PH_HUNT;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A status beat always closes the run, and only a status beat does
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == is_status))
    else $error("last does not match is_status");

  // Update beats carry an ok code
  a_update_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_status) |-> (status == ST_OK))
    else $error("update beat with nonzero status");

  // Payload phase never holds more bytes than the frame length
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD && state == S_IDLE) |-> (bytes_taken < frame_length))
    else $error("payload count reached frame length without leaving payload phase");

  // Emission reads only pairs inside the frame
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_IDX) |-> (ptr < frame_length))
    else $error("pair pointer past frame length");

  // A new result beat is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(last) && $stable(status)))
    else $error("pending result beat overwritten");

endmodule
